>>> design/tmq_pkg.sv
//------------------------------------------------------------------------------
// tmq_pkg
// Shared types and constants of the typed message queue.
//------------------------------------------------------------------------------
`default_nettype none
package tmq_pkg;
  localparam int MAX_MSGS      = 16;
  localparam int MAX_MSG_BYTES = 64;
  localparam int SLOT_W = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
  localparam int BYTE_W = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
  localparam int CNT_W  = $clog2(MAX_MSGS + 1);
  localparam int PAY_DEPTH = MAX_MSGS * MAX_MSG_BYTES;
  localparam int PAY_AW = SLOT_W + BYTE_W;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_MESSAGE = 3'd1;
  localparam logic [2:0] ST_QUEUE_FULL = 3'd2;
  localparam logic [2:0] ST_TOO_BIG    = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd4;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] msg_type;
    logic [7:0]         data_byte;
    logic [6:0]         msg_size;
    logic               last_byte;
    logic               no_error;
  } tmq_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] recv_type;
    logic [7:0]         out_byte;
    logic [6:0]         byte_count;
    logic               last;
  } tmq_out_t;
endpackage
`default_nettype wire

>>> design/tmq_ram.sv
//------------------------------------------------------------------------------
// tmq_ram
// Generic single-port-write, one-read synchronous RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none
module tmq_ram #(
  parameter int W = 8,
  parameter int D = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/typed_message_queue_top.sv
//------------------------------------------------------------------------------
// typed_message_queue_top
// Fixed pool of typed message slots kept in arrival order.
//------------------------------------------------------------------------------
// Usage: drive req with start while busy is low. A send is a run of byte
// beats (req_type 0); the final beat (last_byte) yields one status beat.
// A receive beat (req_type 1) yields one status beat, or one beat per
// delivered byte with last on the final one. Results appear on rsp for one
// cycle with rsp_valid; the receiver cannot stall.
// Sequencing: a send beat holds busy high for a single cycle (S_SEND), and
// the status of the last beat is registered onto rsp in S_SEND. A receive
// checks the queued slots one by one through the slot RAM (S_SCAN, S_CHK),
// then streams bytes from the payload RAM (S_BYTE, S_SHW per byte), then
// closes up the order list one entry per cycle (S_SHIFT) and ends in S_DONE.
// A miss ends in S_SCAN once every queued slot has been checked, with a
// NO_MESSAGE status beat.
// Reset zeroes the queue count, marks every slot free, clears send progress;
// the RAM contents are never read before written, so no clearing pass.
//------------------------------------------------------------------------------
`default_nettype none
module typed_message_queue_top
  import tmq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire tmq_in_t req,
  output logic         rsp_valid,
  output tmq_out_t     rsp
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SEND  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_CHK   = 9'b000001000,
    S_LEN   = 9'b000010000,
    S_BYTE  = 9'b000100000,
    S_SHIFT = 9'b001000000,
    S_SHW   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;
  state_t state;

  tmq_in_t         r;
  logic [CNT_W-1:0] qcount;
  logic [MAX_MSGS-1:0] free_slots;
  logic            snd_active;
  logic [2:0]      snd_error;
  logic [SLOT_W-1:0] snd_slot;
  logic [6:0]      snd_len;
  logic [6:0]      snd_items;
  logic [CNT_W-1:0] pos;
  logic [SLOT_W-1:0] cur_slot;
  logic [6:0]      n, bi;
  logic signed [32:0] mag;

  // order list: small register array of slot indices, oldest message first
  logic [SLOT_W-1:0] order_list [MAX_MSGS];

  // slot RAM: length and type side by side
  logic tw_we; logic [SLOT_W-1:0] t_waddr, t_raddr;
  logic [38:0] m_rdata;
  logic [31:0] t_rdata; logic [6:0] l_rdata;
  tmq_ram #(.W(39), .D(MAX_MSGS)) u_meta (
    .clk, .we(tw_we), .waddr(t_waddr), .wdata({req.msg_size, req.msg_type}),
    .raddr(t_raddr), .rdata(m_rdata));
  assign t_rdata = m_rdata[31:0];
  assign l_rdata = m_rdata[38:32];

  logic p_we; logic [PAY_AW-1:0] p_waddr, p_raddr; logic [7:0] p_rdata;
  tmq_ram #(.W(8), .D(PAY_DEPTH)) u_pay (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(r.data_byte),
    .raddr(p_raddr), .rdata(p_rdata));

  // lowest free slot
  logic found; logic [SLOT_W-1:0] fslot;
  always_comb begin
    found = 1'b0; fslot = '0;
    for (int i = MAX_MSGS - 1; i >= 0; i--) begin
      if (free_slots[i]) begin found = 1'b1; fslot = SLOT_W'(i); end
    end
  end

  logic accept;
  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  logic first_new;
  assign first_new = accept && !req.req_type && !snd_active;
  assign tw_we = first_new && (req.msg_size <= 7'(MAX_MSG_BYTES)) && found;
  assign t_waddr = fslot;

  logic [6:0] want;
  assign want = (snd_len == 7'd0) ? 7'd1 : snd_len;
  assign p_we = (state == S_SEND) && (snd_error == ST_OK) && (snd_items < snd_len)
                && (snd_items < 7'(MAX_MSG_BYTES));
  assign p_waddr = {snd_slot, snd_items[BYTE_W-1:0]};
  assign p_raddr = {cur_slot, bi[BYTE_W-1:0]};

  // status of a send at its last beat
  logic [2:0] snd_status;
  always_comb begin
    snd_status = snd_error;
    if (snd_error == ST_OK) begin
      if (snd_items + 7'd1 != want) snd_status = ST_BAD_SIZE;
      else if (qcount >= CNT_W'(MAX_MSGS)) snd_status = ST_QUEUE_FULL;
    end
  end

  logic [SLOT_W-1:0] ol_at_pos;
  assign ol_at_pos = order_list[pos[SLOT_W-1:0]];
  always_comb begin
    t_raddr = ol_at_pos;
    if (state == S_CHK || state == S_LEN) t_raddr = cur_slot;
  end

  logic signed [32:0] tval;
  assign tval = {t_rdata[31], t_rdata};
  logic hit;
  always_comb begin
    if (r.msg_type == 0) hit = 1'b1;
    else if (!r.msg_type[31]) hit = (t_rdata == r.msg_type);
    else hit = (tval <= mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      state <= S_IDLE; qcount <= '0; free_slots <= '1;
      snd_active <= 1'b0; snd_error <= ST_OK; snd_items <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          rsp_valid <= 1'b0;
          if (accept) begin
            r <= req;
            if (req.req_type) begin
              pos <= '0;
              mag <= req.msg_type[31] ?
                     ((req.msg_type == 32'sh80000000) ? 33'sd2147483647
                      : -{req.msg_type[31], req.msg_type}) : {1'b0, req.msg_type};
              state <= S_SCAN;
            end else begin
              if (!snd_active) begin
                snd_active <= 1'b1; snd_items <= '0; snd_slot <= fslot;
                snd_len <= req.msg_size;
                if (req.msg_size > 7'(MAX_MSG_BYTES)) snd_error <= ST_BAD_SIZE;
                else if (!found) snd_error <= ST_QUEUE_FULL;
                else begin
                  snd_error <= ST_OK; free_slots[fslot] <= 1'b0;
                end
              end
              state <= S_SEND;
            end
          end
        end
        S_SEND: begin
          state <= S_IDLE;
          rsp_valid <= r.last_byte;
          if (r.last_byte) begin
            rsp <= '{status: snd_status, recv_type: '0, out_byte: '0,
                     byte_count: '0, last: 1'b1};
            if (snd_error == ST_OK) begin
              if (snd_status == ST_OK) begin
                order_list[qcount[SLOT_W-1:0]] <= snd_slot;
                qcount <= qcount + 1'b1;
              end else free_slots[snd_slot] <= 1'b1;
            end
            snd_active <= 1'b0; snd_error <= ST_OK; snd_items <= '0;
          end else if (snd_items < 7'd127) snd_items <= snd_items + 7'd1;
        end
        S_SCAN: begin
          if (pos >= qcount) begin
            rsp_valid <= 1'b1;
            rsp <= '{status: ST_NO_MESSAGE, recv_type: '0, out_byte: '0,
                     byte_count: '0, last: 1'b1};
            state <= S_IDLE;
          end else begin
            rsp_valid <= 1'b0;
            cur_slot <= ol_at_pos;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          rsp_valid <= 1'b0;
          if (hit) state <= S_LEN;
          else begin pos <= pos + 1'b1; state <= S_SCAN; end
        end
        S_LEN: begin
          bi <= '0;
          n <= (l_rdata > r.msg_size) ? r.msg_size : l_rdata;
          if (l_rdata > r.msg_size && !r.no_error) begin
            rsp_valid <= 1'b1;
            rsp <= '{status: ST_TOO_BIG, recv_type: '0, out_byte: '0,
                     byte_count: '0, last: 1'b1};
            state <= S_IDLE;
          end else if (l_rdata == 7'd0 || r.msg_size == 7'd0) begin
            rsp_valid <= 1'b1;
            rsp <= '{status: ST_OK, recv_type: t_rdata, out_byte: '0,
                     byte_count: '0, last: 1'b1};
            state <= S_SHIFT;
          end else begin
            rsp_valid <= 1'b0;
            rsp.recv_type <= t_rdata;
            state <= S_BYTE;
          end
        end
        S_BYTE: begin
          rsp_valid <= 1'b0;
          bi <= bi + 7'd1;
          state <= S_SHW;
        end
        S_SHW: begin
          rsp_valid <= 1'b1;
          rsp.status <= ST_OK; rsp.out_byte <= p_rdata; rsp.byte_count <= n;
          rsp.last <= (bi == n);
          state <= (bi == n) ? S_SHIFT : S_BYTE;
        end
        S_SHIFT: begin
          rsp_valid <= 1'b0;
          if (pos + 1'b1 < qcount) begin
            order_list[pos[SLOT_W-1:0]] <= order_list[SLOT_W'(pos + 1'b1)];
            pos <= pos + 1'b1;
          end else begin
            qcount <= qcount - 1'b1;
            free_slots[cur_slot] <= 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          rsp_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          rsp_valid <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire
